### rtl/crat_pkg.sv
package crat_pkg;

    localparam int TimeW = 32;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_NEXT    = 3'd1,
        OP_MARK    = 3'd2,
        OP_ACK     = 3'd3,
        OP_CONFIRM = 3'd4,
        OP_CLEANUP = 3'd5,
        OP_PCOUNT  = 3'd6,
        OP_BUSY    = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        PH_PENDING = 3'd0,
        PH_SENT    = 3'd1,
        PH_ACKED   = 3'd2,
        PH_DONE    = 3'd3,
        PH_FAILED  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_ACK_TIMEOUT     = 3'd0,
        REG_RETRY_DELAY     = 3'd1,
        REG_CONFIRM_TIMEOUT = 3'd2,
        REG_RETRY_LIMIT     = 3'd3,
        REG_RETENTION_TIME  = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2,
        S_OUT  = 2'd3
    } fsm_state_t;

    localparam logic signed [16:0] TempTol = 17'sd10;

    typedef struct packed {
        logic [2:0]         op;
        logic [31:0]        now_ms;
        logic [7:0]         handle_in;
        logic [23:0]        target_id;
        logic [7:0]         seq_num;
        logic [4:0]         present_mask;
        logic               power_on;
        logic [3:0]         op_mode;
        logic signed [15:0] temp_hundredths;
        logic [3:0]         fan_setting;
        logic [3:0]         preset_code;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  handle_out;
        logic [23:0] chosen_target;
        logic [4:0]  pending_total;
        logic        target_busy;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;
    } dp_stat_t;

    // packed expected or reported state: power, mode, temp, fan, preset
    function automatic logic [28:0] pack_values(req_t r);
        pack_values = {r.preset_code, r.fan_setting, r.temp_hundredths, r.op_mode, r.power_on};
    endfunction

endpackage

### rtl/crat_ctrl.sv
module crat_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output crat_pkg::dp_cmd_t    cmd,
    input  crat_pkg::dp_stat_t   stat
);

    crat_pkg::fsm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crat_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        case (state_reg)
            crat_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = crat_pkg::S_SCAN;
                end
            end
            crat_pkg::S_SCAN: begin
                cmd.step = 1'b1;
                if (stat.last) begin
                    state_next = crat_pkg::S_DONE;
                end
            end
            crat_pkg::S_DONE: begin
                cmd.finish = 1'b1;
                state_next = crat_pkg::S_OUT;
            end
            crat_pkg::S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = crat_pkg::S_IDLE;
                end
            end
            default: state_next = crat_pkg::S_IDLE;
        endcase
    end

endmodule

### rtl/crat_dp.sv
module crat_dp #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  crat_pkg::req_t       req,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_idx,
    input  logic [31:0]          cfg_data,
    input  crat_pkg::dp_cmd_t    cmd,
    output crat_pkg::dp_stat_t   stat,
    output crat_pkg::rsp_t       rsp
);

    localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CntW = $clog2(TABLE_DEPTH + 1);

    logic [31:0] ack_timeout_reg, retry_delay_reg, confirm_timeout_reg, retention_reg;
    logic [3:0]  retry_limit_reg;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;
    logic [2:0]  phase_reg  [TABLE_DEPTH];
    logic [31:0] time_reg   [TABLE_DEPTH];
    logic [7:0]  seq_reg    [TABLE_DEPTH];
    logic [3:0]  tries_reg  [TABLE_DEPTH];
    logic [23:0] target_reg [TABLE_DEPTH];
    logic [7:0]  handle_reg [TABLE_DEPTH];
    logic [4:0]  mask_reg   [TABLE_DEPTH];
    logic [28:0] values_reg [TABLE_DEPTH];

    logic [7:0]       next_handle_reg;
    crat_pkg::req_t   req_reg;
    logic [IdxW-1:0]  idx_reg;
    logic [CntW-1:0]  wr_reg;
    logic             hit_reg;
    logic             any_reg;
    logic [CntW-1:0]  cnt_reg;
    logic [7:0]       hout_reg;
    logic [23:0]      ctgt_reg;
    crat_pkg::rsp_t   rsp_reg;
    crat_pkg::rsp_t   rsp_next;

    // current slot fields
    logic        v;
    logic [2:0]  ph;
    logic [31:0] age;
    logic [2:0]  ph_new;
    logic [28:0] rep;
    logic        match;
    logic signed [16:0] tdiff;
    logic        last;
    logic        keep;

    assign v    = valid_reg[idx_reg];
    assign ph   = phase_reg[idx_reg];
    assign age  = req_reg.now_ms - time_reg[idx_reg];
    assign rep  = crat_pkg::pack_values(req_reg);
    assign last = (idx_reg == IdxW'(TABLE_DEPTH - 1));

    always_comb begin
        ph_new = ph;
        if (ph == crat_pkg::PH_SENT) begin
            if (age > ack_timeout_reg) begin
                if (tries_reg[idx_reg] < retry_limit_reg) begin
                    if ({1'b0, age} > ({1'b0, ack_timeout_reg} + {1'b0, retry_delay_reg})) begin
                        ph_new = crat_pkg::PH_PENDING;
                    end
                end else begin
                    ph_new = crat_pkg::PH_FAILED;
                end
            end
        end else if (ph == crat_pkg::PH_ACKED) begin
            if (age > confirm_timeout_reg) begin
                ph_new = crat_pkg::PH_DONE;
            end
        end
    end

    always_comb begin
        tdiff = 17'(signed'(rep[20:5])) - 17'(signed'(values_reg[idx_reg][20:5]));
        match = 1'b1;
        if (mask_reg[idx_reg][0] && (rep[0] != values_reg[idx_reg][0])) match = 1'b0;
        if (mask_reg[idx_reg][1] && (rep[4:1] != values_reg[idx_reg][4:1])) match = 1'b0;
        if (mask_reg[idx_reg][2] && ((tdiff > crat_pkg::TempTol) || (tdiff < -crat_pkg::TempTol)))
            match = 1'b0;
        if (mask_reg[idx_reg][3] && (rep[24:21] != values_reg[idx_reg][24:21])) match = 1'b0;
        if (mask_reg[idx_reg][4] && (rep[28:25] != values_reg[idx_reg][28:25])) match = 1'b0;
    end

    assign keep = !(((ph == crat_pkg::PH_DONE) || (ph == crat_pkg::PH_FAILED))
                    && (age > retention_reg));

    assign stat.last = last;
    assign rsp       = rsp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_timeout_reg     <= 32'd1000;
            retry_delay_reg     <= 32'd500;
            confirm_timeout_reg <= 32'd5000;
            retry_limit_reg     <= 4'd3;
            retention_reg       <= 32'd10000;
        end else if (cfg_we) begin
            case (cfg_idx)
                crat_pkg::REG_ACK_TIMEOUT:     ack_timeout_reg     <= cfg_data;
                crat_pkg::REG_RETRY_DELAY:     retry_delay_reg     <= cfg_data;
                crat_pkg::REG_CONFIRM_TIMEOUT: confirm_timeout_reg <= cfg_data;
                crat_pkg::REG_RETRY_LIMIT:     retry_limit_reg     <= cfg_data[3:0];
                crat_pkg::REG_RETENTION_TIME:  retention_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.step) begin
            case (crat_pkg::op_t'(req_reg.op))
                crat_pkg::OP_ADD: begin
                    if (!hit_reg && !v) begin
                        valid_next[idx_reg] = 1'b1;
                    end
                end
                crat_pkg::OP_CLEANUP: begin
                    // compaction: kept entries move down to the write index
                    if (wr_reg != CntW'(idx_reg) || !(v && keep)) begin
                        valid_next[idx_reg] = 1'b0;
                    end
                    if (v && keep) begin
                        valid_next[wr_reg[IdxW-1:0]] = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            next_handle_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            if (cmd.step && (crat_pkg::op_t'(req_reg.op) == crat_pkg::OP_ADD)
                && !hit_reg && !v) begin
                next_handle_reg <= next_handle_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= req;
            idx_reg  <= '0;
            wr_reg   <= '0;
            hit_reg  <= 1'b0;
            any_reg  <= 1'b0;
            cnt_reg  <= '0;
            hout_reg <= '0;
            ctgt_reg <= '0;
        end else if (cmd.step) begin
            if (!last) idx_reg <= idx_reg + IdxW'(1);
            case (crat_pkg::op_t'(req_reg.op))
                crat_pkg::OP_ADD: begin
                    if (!hit_reg && !v) begin
                        hit_reg             <= 1'b1;
                        hout_reg            <= next_handle_reg;
                        phase_reg[idx_reg]  <= crat_pkg::PH_PENDING;
                        time_reg[idx_reg]   <= req_reg.now_ms;
                        seq_reg[idx_reg]    <= '0;
                        tries_reg[idx_reg]  <= '0;
                        target_reg[idx_reg] <= req_reg.target_id;
                        handle_reg[idx_reg] <= next_handle_reg;
                        mask_reg[idx_reg]   <= req_reg.present_mask;
                        values_reg[idx_reg] <= rep;
                    end
                end
                crat_pkg::OP_NEXT: begin
                    if (!hit_reg && v) begin
                        phase_reg[idx_reg] <= ph_new;
                        if (ph_new == crat_pkg::PH_PENDING) begin
                            hit_reg  <= 1'b1;
                            hout_reg <= handle_reg[idx_reg];
                            ctgt_reg <= target_reg[idx_reg];
                        end
                    end
                end
                crat_pkg::OP_MARK: begin
                    if (!hit_reg && v && handle_reg[idx_reg] == req_reg.handle_in) begin
                        hit_reg            <= 1'b1;
                        phase_reg[idx_reg] <= crat_pkg::PH_SENT;
                        time_reg[idx_reg]  <= req_reg.now_ms;
                        seq_reg[idx_reg]   <= req_reg.seq_num;
                        if (tries_reg[idx_reg] != 4'hF) begin
                            tries_reg[idx_reg] <= tries_reg[idx_reg] + 4'd1;
                        end
                    end
                end
                crat_pkg::OP_ACK: begin
                    if (!hit_reg && v && ph == crat_pkg::PH_SENT
                        && seq_reg[idx_reg] == req_reg.seq_num) begin
                        hit_reg            <= 1'b1;
                        phase_reg[idx_reg] <= crat_pkg::PH_ACKED;
                        time_reg[idx_reg]  <= req_reg.now_ms;
                    end
                end
                crat_pkg::OP_CONFIRM: begin
                    if (v && target_reg[idx_reg] == req_reg.target_id
                        && ph == crat_pkg::PH_ACKED && match) begin
                        hit_reg            <= 1'b1;
                        phase_reg[idx_reg] <= crat_pkg::PH_DONE;
                    end
                end
                crat_pkg::OP_CLEANUP: begin
                    if (v && keep) begin
                        wr_reg <= wr_reg + CntW'(1);
                        phase_reg[wr_reg[IdxW-1:0]]  <= phase_reg[idx_reg];
                        time_reg[wr_reg[IdxW-1:0]]   <= time_reg[idx_reg];
                        seq_reg[wr_reg[IdxW-1:0]]    <= seq_reg[idx_reg];
                        tries_reg[wr_reg[IdxW-1:0]]  <= tries_reg[idx_reg];
                        target_reg[wr_reg[IdxW-1:0]] <= target_reg[idx_reg];
                        handle_reg[wr_reg[IdxW-1:0]] <= handle_reg[idx_reg];
                        mask_reg[wr_reg[IdxW-1:0]]   <= mask_reg[idx_reg];
                        values_reg[wr_reg[IdxW-1:0]] <= values_reg[idx_reg];
                    end
                end
                crat_pkg::OP_PCOUNT: begin
                    if (v && (ph == crat_pkg::PH_PENDING || ph == crat_pkg::PH_SENT)) begin
                        cnt_reg <= cnt_reg + CntW'(1);
                    end
                end
                default: begin
                    if (v && target_reg[idx_reg] == req_reg.target_id
                        && (ph == crat_pkg::PH_PENDING || ph == crat_pkg::PH_SENT
                            || ph == crat_pkg::PH_ACKED)) begin
                        any_reg <= 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb begin
        rsp_next = '0;
        case (crat_pkg::op_t'(req_reg.op))
            crat_pkg::OP_ADD: begin
                rsp_next.status     = hit_reg ? crat_pkg::ST_OK : crat_pkg::ST_FULL;
                rsp_next.handle_out = hout_reg;
            end
            crat_pkg::OP_NEXT: begin
                rsp_next.status        = hit_reg ? crat_pkg::ST_OK : crat_pkg::ST_NONE;
                rsp_next.handle_out    = hout_reg;
                rsp_next.chosen_target = ctgt_reg;
            end
            crat_pkg::OP_MARK, crat_pkg::OP_ACK, crat_pkg::OP_CONFIRM: begin
                rsp_next.status = hit_reg ? crat_pkg::ST_OK : crat_pkg::ST_NONE;
            end
            crat_pkg::OP_PCOUNT: begin
                rsp_next.status        = crat_pkg::ST_OK;
                rsp_next.pending_total = 5'(cnt_reg);
            end
            crat_pkg::OP_BUSY: begin
                rsp_next.status      = crat_pkg::ST_OK;
                rsp_next.target_busy = any_reg;
            end
            default: rsp_next.status = crat_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

### rtl/command_retry_ack_tracker.sv
// command retry and ack tracker
// s_ channel takes one request word (op, time, handle, target, seq, device
// state); m_ channel returns one response word for each request.
// configuration: cfg_we, cfg_idx, cfg_data write ack timeout, retry delay,
// confirm timeout, retry limit and retention time; write only while idle.
// after acceptance, a scan visits one table slot per cycle, then the
// response is registered and presented on m_; one request is in flight
// at a time.
// reset empties the table, zeroes the handle counter and loads the default
// timeouts. when the receiver stalls, the response holds on m_ and s_ready
// stays low until it is taken.
module command_retry_ack_tracker #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  crat_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output crat_pkg::rsp_t  m_data,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_idx,
    input  logic [31:0]     cfg_data
);

    crat_pkg::dp_cmd_t  cmd;
    crat_pkg::dp_stat_t stat;

    crat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    crat_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (s_data),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .rsp      (m_data)
    );

endmodule

### rtl/crat_checker.sv
module crat_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input crat_pkg::rsp_t  m_data
);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input ready while response held");

    a_rsp_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("response changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.status == crat_pkg::ST_OK)
                     || (m_data.status == crat_pkg::ST_FULL)
                     || (m_data.status == crat_pkg::ST_NONE)))
        else $error("bad status code");

    a_accept_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && !m_valid))
        else $error("request not processed");

endmodule

bind command_retry_ack_tracker crat_checker u_crat_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
